/* sv/dbs_pkg.sv */
// ============================================================================
// dbs_pkg: shared types and constants of the disc brush stamp frame buffer
// Command and register codes, field widths, reset values and the status
// record that the stamp walker hands to the sequencer.
// ============================================================================
package dbs_pkg;

   // Default build-time limits.
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int DEF_MAX_RADIUS = 32;

   // Field widths.
   localparam int CMD_W        = 3;
   localparam int COORD_W      = 13;
   localparam int COLOR_W      = 32;
   localparam int COUNT_W      = 17;
   localparam int DIM_W        = 13;   // effective width or height, up to 4096
   localparam int IDX_W        = 12;   // in-canvas column or row index
   localparam int CW           = 14;   // coordinate plus stamp offset
   localparam int PROD_W       = IDX_W + DIM_W;
   localparam int N_W          = 2 * DIM_W;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 32;
   localparam int WIDTH_REG_W  = 9;
   localparam int RADIUS_REG_W = 6;
   localparam int GREY_LANES   = 4;

   // Constants.
   localparam logic [7:0]         OPAQUE_ALPHA = 8'd255;
   localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

   // Register reset values.
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 9'd256;
   localparam logic [WIDTH_REG_W-1:0]  HEIGHT_RESET = 9'd256;
   localparam logic [RADIUS_REG_W-1:0] RADIUS_RESET = 6'd4;
   localparam logic [COLOR_W-1:0]      COLOR_RESET  = 32'hFF00_0000;

   // Command codes; the remaining codes do nothing.
   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR       = 3'd0,
      CMD_DOT         = 3'd1,
      CMD_WRITE_COLOR = 3'd2,
      CMD_WRITE_GREY  = 3'd3,
      CMD_READ        = 3'd4
   } cmd_type;

   // Register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CANVAS_WIDTH  = 2'd0,
      CSR_CANVAS_HEIGHT = 2'd1,
      CSR_BRUSH_RADIUS  = 2'd2,
      CSR_BRUSH_COLOR   = 2'd3
   } csr_type;

   // Stamp walker status toward the sequencer.
   typedef struct packed {
      logic               done;
      logic [COUNT_W-1:0] count;
   } stamp_stat_type;

endpackage

/* sv/dbs_if.sv */
// ============================================================================
// dbs_if: command and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ============================================================================

// Command channel.
interface dbs_req_if;
   logic                                valid;
   logic                                ready;
   logic [dbs_pkg::CMD_W-1:0]           command;
   logic signed [dbs_pkg::COORD_W-1:0]  coord_x;
   logic signed [dbs_pkg::COORD_W-1:0]  coord_y;
   logic [dbs_pkg::COLOR_W-1:0]         pixel_value;

   modport source (output valid, command, coord_x, coord_y, pixel_value, input ready);
   modport sink   (input valid, command, coord_x, coord_y, pixel_value, output ready);
endinterface

// Result channel.
interface dbs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [dbs_pkg::COLOR_W-1:0]  read_color;
   logic                         in_bounds;
   logic [dbs_pkg::COUNT_W-1:0]  written_count;

   modport source (output valid, read_color, in_bounds, written_count, input ready);
   modport sink   (input valid, read_color, in_bounds, written_count, output ready);
endinterface

/* sv/disc_brush_stamp_framebuffer.sv */
// ============================================================================
// disc_brush_stamp_framebuffer: filled disc brush rasterizer over an RGBA store
// Clear, disc stamp, single-pixel write and read on a 32-bit frame store.
// ============================================================================
// One command is worked at a time against the frame store, whose single
// write port paces clears and stamps at one pixel per cycle. A clear
// sweeps the W*H words of the canvas and a disc stamp walks the (2r)^2
// offset square (64 positions at the reset radius of 4). The result beat
// sits in an output register, so the next command is taken while it waits.
// After reset the store is zeroed by a sweep over all MAX_WIDTH*MAX_HEIGHT
// words (65536 by default) during which no command is taken; register
// writes are taken at any time.
module disc_brush_stamp_framebuffer #(
   parameter int MAX_WIDTH  = dbs_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = dbs_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS = dbs_pkg::DEF_MAX_RADIUS
) (
   input  logic                              clock,
   input  logic                              reset,
   dbs_req_if.sink                           req_chan,
   dbs_rsp_if.source                         rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [dbs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dbs_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
   localparam int RC_W   = RAD_W + dbs_pkg::RADIUS_REG_W;

   logic [dbs_pkg::WIDTH_REG_W-1:0]  canvas_width_ff, canvas_height_ff;
   logic [dbs_pkg::RADIUS_REG_W-1:0] brush_radius_ff;
   logic [dbs_pkg::COLOR_W-1:0]      brush_color_ff;

   logic [dbs_pkg::DIM_W-1:0] eff_width, eff_height;
   logic [RAD_W-1:0]          eff_radius;

   logic                               stamp_start;
   logic signed [dbs_pkg::COORD_W-1:0] center_x, center_y;
   dbs_pkg::stamp_stat_type            stamp_stat;
   logic                               stamp_wr_en;
   logic [ADDR_W-1:0]                  stamp_wr_addr;
   logic [dbs_pkg::COLOR_W-1:0]        stamp_wr_data;

   logic                        mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0]           mem_wr_addr, mem_rd_addr;
   logic [dbs_pkg::COLOR_W-1:0] mem_wr_data, mem_rd_data;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_width_ff  <= dbs_pkg::WIDTH_RESET;
         canvas_height_ff <= dbs_pkg::HEIGHT_RESET;
         brush_radius_ff  <= dbs_pkg::RADIUS_RESET;
         brush_color_ff   <= dbs_pkg::COLOR_RESET;
      end else if (csr_wr_en) begin
         case (dbs_pkg::csr_type'(csr_index))
            dbs_pkg::CSR_CANVAS_WIDTH: begin
               canvas_width_ff <= csr_wr_data[dbs_pkg::WIDTH_REG_W-1:0];
            end
            dbs_pkg::CSR_CANVAS_HEIGHT: begin
               canvas_height_ff <= csr_wr_data[dbs_pkg::WIDTH_REG_W-1:0];
            end
            dbs_pkg::CSR_BRUSH_RADIUS: begin
               brush_radius_ff <= csr_wr_data[dbs_pkg::RADIUS_REG_W-1:0];
            end
            dbs_pkg::CSR_BRUSH_COLOR: begin
               brush_color_ff <= csr_wr_data[dbs_pkg::COLOR_W-1:0];
            end
            default: begin
               brush_color_ff <= brush_color_ff;
            end
         endcase
      end
   end

   // Canvas and radius limited to the build size.
   assign eff_width  = (dbs_pkg::DIM_W'(canvas_width_ff) > dbs_pkg::DIM_W'(MAX_WIDTH))
                     ? dbs_pkg::DIM_W'(MAX_WIDTH) : dbs_pkg::DIM_W'(canvas_width_ff);
   assign eff_height = (dbs_pkg::DIM_W'(canvas_height_ff) > dbs_pkg::DIM_W'(MAX_HEIGHT))
                     ? dbs_pkg::DIM_W'(MAX_HEIGHT) : dbs_pkg::DIM_W'(canvas_height_ff);
   assign eff_radius = (RC_W'(brush_radius_ff) > RC_W'(MAX_RADIUS))
                     ? RAD_W'(MAX_RADIUS) : RAD_W'(brush_radius_ff);

   dbs_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .ADDR_W     (ADDR_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .width         (eff_width),
      .height        (eff_height),
      .brush_color   (brush_color_ff),
      .stamp_start   (stamp_start),
      .center_x      (center_x),
      .center_y      (center_y),
      .stamp_stat    (stamp_stat),
      .stamp_wr_en   (stamp_wr_en),
      .stamp_wr_addr (stamp_wr_addr),
      .stamp_wr_data (stamp_wr_data),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data)
   );

   dbs_stamp #(
      .MAX_RADIUS (MAX_RADIUS),
      .ADDR_W     (ADDR_W)
   ) u_stamp (
      .clock    (clock),
      .reset    (reset),
      .start    (stamp_start),
      .center_x (center_x),
      .center_y (center_y),
      .width    (eff_width),
      .height   (eff_height),
      .radius   (eff_radius),
      .color    (brush_color_ff),
      .stat     (stamp_stat),
      .wr_en    (stamp_wr_en),
      .wr_addr  (stamp_wr_addr),
      .wr_data  (stamp_wr_data)
   );

   dbs_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

/* sv/dbs_mem.sv */
// ============================================================================
// dbs_mem: frame store
// Single-port-write, single-port-read synchronous RAM with registered read
// data, valid in the cycle after the read is enabled.
// ============================================================================
module dbs_mem #(
   parameter int DEPTH  = 65536,
   parameter int ADDR_W = 16
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [dbs_pkg::COLOR_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [dbs_pkg::COLOR_W-1:0] rd_data
);

   logic [dbs_pkg::COLOR_W-1:0] store [DEPTH];
   logic [dbs_pkg::COLOR_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
   end

   // Read port with registered data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/dbs_stamp.sv */
// ============================================================================
// dbs_stamp: disc stamp walker
// Walks the (2r)^2 offset square one pixel per cycle through a two-stage
// pipeline: squares, target and row address first, then the disc test and
// the frame store write.
// ============================================================================
module dbs_stamp #(
   parameter int MAX_RADIUS = 32,
   parameter int ADDR_W     = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [dbs_pkg::COORD_W-1:0]  center_x,
   input  logic signed [dbs_pkg::COORD_W-1:0]  center_y,
   input  logic [dbs_pkg::DIM_W-1:0]           width,
   input  logic [dbs_pkg::DIM_W-1:0]           height,
   input  logic [$clog2(MAX_RADIUS+1)-1:0]     radius,
   input  logic [dbs_pkg::COLOR_W-1:0]         color,
   output dbs_pkg::stamp_stat_type             stat,
   output logic                                wr_en,
   output logic [ADDR_W-1:0]                   wr_addr,
   output logic [dbs_pkg::COLOR_W-1:0]         wr_data
);

   localparam int PX_W  = $clog2(MAX_RADIUS) + 1;
   localparam int SQ_W  = 2 * PX_W;
   localparam int SUM_W = SQ_W + 1;
   localparam int CW    = dbs_pkg::CW;

   // Walk control.
   logic                     run_ff;
   logic signed [PX_W-1:0]   px_ff, py_ff;
   logic signed [PX_W-1:0]   r_neg_ff, r_last_ff;
   logic [SQ_W-1:0]          rsq_ff;
   logic signed [PX_W-1:0]   r_neg, r_last;
   logic                     at_row_end, at_last;

   // First stage.
   logic signed [CW-1:0]     tx, ty;
   logic signed [SQ_W-1:0]   px_ext, py_ext;
   logic [SQ_W-1:0]          px_sq, py_sq;
   logic                     tgt_inb;
   logic [dbs_pkg::PROD_W-1:0] ty_w;

   logic                     s1_valid_ff, s1_last_ff, s1_inb_ff;
   logic [SQ_W-1:0]          s1_pxsq_ff, s1_pysq_ff;
   logic [dbs_pkg::IDX_W-1:0]  s1_tx_ff;
   logic [dbs_pkg::PROD_W-1:0] s1_tyw_ff;

   // Second stage.
   logic [SUM_W-1:0]           dist_sq;
   logic [dbs_pkg::PROD_W-1:0] addr_full;
   logic                       hit;
   logic [dbs_pkg::COUNT_W-1:0] cnt_ff;
   logic                        done_ff;

   // Offset limits from the radius at start.
   assign r_neg  = PX_W'(0) - PX_W'(radius);
   assign r_last = PX_W'(radius) - PX_W'(1);

   assign at_row_end = (px_ff == r_last_ff);
   assign at_last    = run_ff && at_row_end && (py_ff == r_last_ff);

   // Walk over rows and columns of the offset square.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else if (start && (radius != '0)) begin
         run_ff <= 1'b1;
      end else if (at_last) begin
         run_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         px_ff     <= r_neg;
         py_ff     <= r_neg;
         r_neg_ff  <= r_neg;
         r_last_ff <= r_last;
         rsq_ff    <= SQ_W'(radius) * SQ_W'(radius);
      end else if (run_ff) begin
         if (at_row_end) begin
            px_ff <= r_neg_ff;
            py_ff <= py_ff + PX_W'(1);
         end else begin
            px_ff <= px_ff + PX_W'(1);
         end
      end
   end

   // Target pixel, clipping and squared offsets.
   assign tx      = CW'(center_x) + CW'(px_ff);
   assign ty      = CW'(center_y) + CW'(py_ff);
   assign tgt_inb = !tx[CW-1] && (tx < $signed({1'b0, width}))
                 && !ty[CW-1] && (ty < $signed({1'b0, height}));
   assign px_ext  = SQ_W'(px_ff);
   assign py_ext  = SQ_W'(py_ff);
   assign px_sq   = px_ext * px_ext;
   assign py_sq   = py_ext * py_ext;
   assign ty_w    = dbs_pkg::PROD_W'(ty[dbs_pkg::IDX_W-1:0]) * dbs_pkg::PROD_W'(width);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= run_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff <= at_last;
      s1_inb_ff  <= tgt_inb;
      s1_pxsq_ff <= px_sq;
      s1_pysq_ff <= py_sq;
      s1_tx_ff   <= tx[dbs_pkg::IDX_W-1:0];
      s1_tyw_ff  <= ty_w;
   end

   // Disc test and write.
   assign dist_sq   = SUM_W'(s1_pxsq_ff) + SUM_W'(s1_pysq_ff);
   assign hit       = s1_valid_ff && s1_inb_ff && (dist_sq < SUM_W'(rsq_ff));
   assign addr_full = dbs_pkg::PROD_W'(s1_tx_ff) + s1_tyw_ff;
   assign wr_en     = hit;
   assign wr_addr   = addr_full[ADDR_W-1:0];
   assign wr_data   = color;

   // Painted pixel count and completion.
   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= '0;
      end else if (hit) begin
         cnt_ff <= cnt_ff + dbs_pkg::COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= (start && (radius == '0)) || (s1_valid_ff && s1_last_ff);
      end
   end

   assign stat.done  = done_ff;
   assign stat.count = cnt_ff;

endmodule

/* sv/dbs_ctrl.sv */
// ============================================================================
// dbs_ctrl: command sequencer
// Takes one command beat at a time, runs the clearing sweeps, single-pixel
// accesses and stamps against the frame store, and holds the result beat in
// an output register so the next command can be taken meanwhile.
// ============================================================================
module dbs_ctrl #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int ADDR_W     = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   dbs_req_if.sink                             req_chan,
   dbs_rsp_if.source                           rsp_chan,
   input  logic [dbs_pkg::DIM_W-1:0]           width,
   input  logic [dbs_pkg::DIM_W-1:0]           height,
   input  logic [dbs_pkg::COLOR_W-1:0]         brush_color,
   output logic                                stamp_start,
   output logic signed [dbs_pkg::COORD_W-1:0]  center_x,
   output logic signed [dbs_pkg::COORD_W-1:0]  center_y,
   input  dbs_pkg::stamp_stat_type             stamp_stat,
   input  logic                                stamp_wr_en,
   input  logic [ADDR_W-1:0]                   stamp_wr_addr,
   input  logic [dbs_pkg::COLOR_W-1:0]         stamp_wr_data,
   output logic                                mem_wr_en,
   output logic [ADDR_W-1:0]                   mem_wr_addr,
   output logic [dbs_pkg::COLOR_W-1:0]         mem_wr_data,
   output logic                                mem_rd_en,
   output logic [ADDR_W-1:0]                   mem_rd_addr,
   input  logic [dbs_pkg::COLOR_W-1:0]         mem_rd_data
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam logic [ADDR_W-1:0] INIT_LAST = ADDR_W'(DEPTH - 1);

   typedef enum logic [7:0] {
      ST_INIT   = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_SETUP  = 8'b0000_0100,
      ST_CLEAR  = 8'b0000_1000,
      ST_STAMP  = 8'b0001_0000,
      ST_ACCESS = 8'b0010_0000,
      ST_READ   = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;

   // Captured command beat.
   logic [dbs_pkg::CMD_W-1:0]          cmd_ff;
   logic signed [dbs_pkg::COORD_W-1:0] x_ff, y_ff;
   logic [dbs_pkg::COLOR_W-1:0]        val_ff;
   dbs_pkg::cmd_type                   cmd;
   logic                               req_beat;

   // Values prepared in setup.
   logic                       inb_ff, pix_inb;
   logic [dbs_pkg::PROD_W-1:0] yw_ff, addr_full;
   logic [dbs_pkg::N_W-1:0]    n_ff;
   logic [ADDR_W-1:0]          pix_addr, clear_last;
   logic [dbs_pkg::COUNT_W-1:0] clear_count;
   logic                        opaque, cmd_addressed;

   // Result being built and result on the channel.
   logic [dbs_pkg::COLOR_W-1:0] res_color_ff, res_color_in;
   logic                        res_inb_ff, res_inb_in;
   logic [dbs_pkg::COUNT_W-1:0] res_count_ff, res_count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [dbs_pkg::COLOR_W-1:0] rsp_color_ff;
   logic                        rsp_inb_ff;
   logic [dbs_pkg::COUNT_W-1:0] rsp_count_ff;
   logic                        rsp_load;

   assign cmd      = dbs_pkg::cmd_type'(cmd_ff);
   assign req_beat = req_chan.valid && req_chan.ready;

   // Pixel checks and addressing for the captured coordinate.
   assign pix_inb = !x_ff[dbs_pkg::COORD_W-1] && (dbs_pkg::DIM_W'(x_ff) < width)
                 && !y_ff[dbs_pkg::COORD_W-1] && (dbs_pkg::DIM_W'(y_ff) < height);
   assign addr_full   = dbs_pkg::PROD_W'(x_ff[dbs_pkg::IDX_W-1:0]) + yw_ff;
   assign pix_addr    = addr_full[ADDR_W-1:0];
   assign clear_last  = ADDR_W'(n_ff - dbs_pkg::N_W'(1));
   assign clear_count = (n_ff > dbs_pkg::N_W'(dbs_pkg::COUNT_MAX)) ? dbs_pkg::COUNT_MAX
                      : n_ff[dbs_pkg::COUNT_W-1:0];
   assign opaque        = (brush_color[31:24] == dbs_pkg::OPAQUE_ALPHA);
   assign cmd_addressed = (cmd == dbs_pkg::CMD_DOT) || (cmd == dbs_pkg::CMD_WRITE_COLOR)
                       || (cmd == dbs_pkg::CMD_WRITE_GREY) || (cmd == dbs_pkg::CMD_READ);

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      res_color_in = res_color_ff;
      res_inb_in   = res_inb_ff;
      res_count_in = res_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_load     = 1'b0;
      stamp_start  = 1'b0;
      case (state_ff)
         ST_INIT: begin
            if (sweep_ff == INIT_LAST) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_beat) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            res_color_in = '0;
            res_count_in = '0;
            res_inb_in   = pix_inb && cmd_addressed;
            sweep_in     = '0;
            case (cmd)
               dbs_pkg::CMD_CLEAR: begin
                  state_in = ST_CLEAR;
               end
               dbs_pkg::CMD_DOT: begin
                  if (opaque) begin
                     stamp_start = 1'b1;
                     state_in    = ST_STAMP;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
               dbs_pkg::CMD_WRITE_COLOR, dbs_pkg::CMD_WRITE_GREY, dbs_pkg::CMD_READ: begin
                  state_in = ST_ACCESS;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_CLEAR: begin
            if ((n_ff == '0) || (sweep_ff == clear_last)) begin
               res_count_in = clear_count;
               state_in     = ST_FINISH;
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end
         ST_STAMP: begin
            if (stamp_stat.done) begin
               res_count_in = stamp_stat.count;
               state_in     = ST_FINISH;
            end
         end
         ST_ACCESS: begin
            if (cmd == dbs_pkg::CMD_READ) begin
               state_in = ST_READ;
            end else begin
               res_count_in = dbs_pkg::COUNT_W'(inb_ff);
               state_in     = ST_FINISH;
            end
         end
         ST_READ: begin
            res_color_in = inb_ff ? mem_rd_data : '0;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_load     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Command capture and setup products.
   always_ff @(posedge clock) begin
      if (req_beat) begin
         cmd_ff <= req_chan.command;
         x_ff   <= req_chan.coord_x;
         y_ff   <= req_chan.coord_y;
         val_ff <= req_chan.pixel_value;
      end
      if (state_ff == ST_SETUP) begin
         inb_ff <= pix_inb;
         yw_ff  <= dbs_pkg::PROD_W'(y_ff[dbs_pkg::IDX_W-1:0]) * dbs_pkg::PROD_W'(width);
         n_ff   <= dbs_pkg::N_W'(width) * dbs_pkg::N_W'(height);
      end
   end

   // Result registers.
   always_ff @(posedge clock) begin
      res_color_ff <= res_color_in;
      res_inb_ff   <= res_inb_in;
      res_count_ff <= res_count_in;
      if (rsp_load) begin
         rsp_color_ff <= res_color_ff;
         rsp_inb_ff   <= res_inb_ff;
         rsp_count_ff <= res_count_ff;
      end
   end

   // Frame store port selection.
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = sweep_ff;
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = pix_addr;
      case (state_ff)
         ST_INIT: begin
            mem_wr_en = 1'b1;
         end
         ST_CLEAR: begin
            mem_wr_en = (n_ff != '0);
         end
         ST_STAMP: begin
            mem_wr_en   = stamp_wr_en;
            mem_wr_addr = stamp_wr_addr;
            mem_wr_data = stamp_wr_data;
         end
         ST_ACCESS: begin
            mem_wr_addr = pix_addr;
            mem_wr_en   = inb_ff && ((cmd == dbs_pkg::CMD_WRITE_COLOR)
                                  || (cmd == dbs_pkg::CMD_WRITE_GREY));
            mem_wr_data = (cmd == dbs_pkg::CMD_WRITE_GREY)
                        ? {dbs_pkg::GREY_LANES{val_ff[7:0]}} : val_ff;
            mem_rd_en   = inb_ff && (cmd == dbs_pkg::CMD_READ);
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   assign center_x              = x_ff;
   assign center_y              = y_ff;
   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.read_color   = rsp_color_ff;
   assign rsp_chan.in_bounds    = rsp_inb_ff;
   assign rsp_chan.written_count = rsp_count_ff;

endmodule

/* sv/dbs_checker.sv */
// ============================================================================
// dbs_checker: port-level checks of the disc brush stamp frame buffer
// Watches the command and result channels and is bound to the top level.
// ============================================================================
module dbs_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [dbs_pkg::COLOR_W-1:0]  rsp_read_color,
   input logic                         rsp_in_bounds,
   input logic [dbs_pkg::COUNT_W-1:0]  rsp_written_count
);

   // A stalled result beat keeps its valid and payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_color)
         && $stable(rsp_in_bounds) && $stable(rsp_written_count))
      else $error("result beat changed while stalled");

   // Commands are worked one at a time.
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command taken while another is at work");

   // The store is being zeroed right after reset.
   a_reset_sweep: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("command port open during the reset sweep");

   // Only a read of a pixel inside the canvas returns a color.
   a_color_inb: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_color != '0) |-> rsp_in_bounds)
      else $error("color returned for a pixel outside the canvas");

endmodule

bind disc_brush_stamp_framebuffer dbs_checker u_dbs_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_read_color    (rsp_chan.read_color),
   .rsp_in_bounds     (rsp_chan.in_bounds),
   .rsp_written_count (rsp_chan.written_count)
);

/* verif/dbs_frame_checker.sv */
`timescale 1ns / 100ps
// ============================================================================
// dbs_frame_checker: result checker for the disc brush stamp frame buffer
// Watches the command, result and register ports, keeps its own copy of
// the frame store and registers, predicts one result per command beat and
// compares every result beat, field by field, with the oldest prediction.
// ============================================================================
module dbs_frame_checker import dbs_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
   input  logic                  clock,
   input  logic                  reset,
   dbs_req_if                    req_mon,
   dbs_rsp_if                    rsp_mon,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output int                    mismatch_count,
   output int                    results_pending
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [COLOR_W-1:0] read_color;
      logic               in_bounds;
      logic [COUNT_W-1:0] written_count;
   } pixel_result_t;

   // Shadow copies of the registers and the frame store.
   logic [WIDTH_REG_W-1:0]  width_reg;
   logic [WIDTH_REG_W-1:0]  height_reg;
   logic [RADIUS_REG_W-1:0] radius_reg;
   logic [COLOR_W-1:0]      color_reg;
   logic [COLOR_W-1:0]      pixel_store [MAX_WIDTH*MAX_HEIGHT];

   // Results predicted for accepted commands, oldest first.
   pixel_result_t awaited_results [$];

   function automatic int clip_dim(input int value, input int limit);
      return (value < limit) ? value : limit;
   endfunction

   function automatic bit on_canvas(input int x, input int y, input int w, input int h);
      return x >= 0 && x < w && y >= 0 && y < h;
   endfunction

   // Applies one command to the shadow store and returns the result it gives.
   function automatic pixel_result_t predict_pixel_result(input logic [CMD_W-1:0] cmd,
                                                          input int x, input int y,
                                                          input logic [COLOR_W-1:0] value);
      pixel_result_t res;
      int            w, h, r, n, i, px, py;
      bit            ok;
      res = '0;
      n   = 0;
      w   = clip_dim(int'(width_reg), MAX_WIDTH);
      h   = clip_dim(int'(height_reg), MAX_HEIGHT);
      ok  = on_canvas(x, y, w, h);
      case (cmd)
         CMD_CLEAR: begin
            n = w * h;
            for (i = 0; i < n; i++) pixel_store[i] = '0;
            res.written_count = (n > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(n);
         end
         CMD_DOT: begin
            res.in_bounds = ok;
            // A brush that is not fully opaque leaves the store untouched.
            if (color_reg[31:24] == OPAQUE_ALPHA) begin
               r = clip_dim(int'(radius_reg), MAX_RADIUS);
               for (py = -r; py < r; py++) begin
                  for (px = -r; px < r; px++) begin
                     if (px * px + py * py < r * r && on_canvas(x + px, y + py, w, h)) begin
                        pixel_store[(x + px) + (y + py) * w] = color_reg;
                        n++;
                     end
                  end
               end
               res.written_count = COUNT_W'(n);
            end
         end
         CMD_WRITE_COLOR: begin
            res.in_bounds = ok;
            if (ok) begin
               pixel_store[x + y * w] = value;
               res.written_count      = 1;
            end
         end
         CMD_WRITE_GREY: begin
            res.in_bounds = ok;
            if (ok) begin
               pixel_store[x + y * w] = {GREY_LANES{value[7:0]}};
               res.written_count      = 1;
            end
         end
         CMD_READ: begin
            res.in_bounds = ok;
            if (ok) res.read_color = pixel_store[x + y * w];
         end
         default: begin
            // Unused command codes change nothing and report all zero.
         end
      endcase
      return res;
   endfunction

   // Result check, command prediction and register tracking at each edge.
   always @(posedge clock) begin
      pixel_result_t want;
      bit            wrong;
      if (reset) begin
         width_reg      = WIDTH_RESET;
         height_reg     = HEIGHT_RESET;
         radius_reg     = RADIUS_RESET;
         color_reg      = COLOR_RESET;
         mismatch_count = 0;
         awaited_results.delete();
         for (int i = 0; i < MAX_WIDTH * MAX_HEIGHT; i++) pixel_store[i] = '0;
      end else begin
         // A result beat is matched against the oldest prediction.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_results.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("%0t: result beat with no command outstanding: color %08h bounds %0d count %0d",
                           $realtime, rsp_mon.read_color, rsp_mon.in_bounds,
                           rsp_mon.written_count);
               mismatch_count++;
            end else begin
               want  = awaited_results.pop_front();
               wrong = 1'b0;
               if (rsp_mon.read_color !== want.read_color) wrong = 1'b1;
               if (rsp_mon.in_bounds !== want.in_bounds) wrong = 1'b1;
               if (rsp_mon.written_count !== want.written_count) wrong = 1'b1;
               if (wrong) begin
                  if (mismatch_count < REPORT_LIMIT)
                     $display("%0t: result mismatch: expected color %08h bounds %0d count %0d, got color %08h bounds %0d count %0d",
                              $realtime, want.read_color, want.in_bounds, want.written_count,
                              rsp_mon.read_color, rsp_mon.in_bounds, rsp_mon.written_count);
                  mismatch_count++;
               end
            end
         end

         // A command beat updates the shadow store and queues its result.
         if (req_mon.valid && req_mon.ready)
            awaited_results.push_back(predict_pixel_result(req_mon.command,
                                                           int'(req_mon.coord_x),
                                                           int'(req_mon.coord_y),
                                                           req_mon.pixel_value));

         // Register writes keep only the bits each register holds.
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CANVAS_WIDTH:  width_reg  = csr_wr_data[WIDTH_REG_W-1:0];
               CSR_CANVAS_HEIGHT: height_reg = csr_wr_data[WIDTH_REG_W-1:0];
               CSR_BRUSH_RADIUS:  radius_reg = csr_wr_data[RADIUS_REG_W-1:0];
               CSR_BRUSH_COLOR:   color_reg  = csr_wr_data;
               default: begin
               end
            endcase
         end
      end
      results_pending = awaited_results.size();
   end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_top: testbench top of the disc brush stamp frame buffer
// Drives a directed command sequence and then random phases under several
// register settings and idle patterns, including a long result stall that
// backs the block up. The checker beside the block predicts and compares.
// ============================================================================
module tb_top;
   import dbs_pkg::*;

   localparam int WATCHDOG_LIMIT   = 300000;  // room for a full clear plus the reset sweep
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES    = 16;
   localparam int FOCUS_SPAN       = 24;
   localparam int SMALL_AREA       = 4096;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   int send_idle_pct;
   int recv_stall_pct;
   bit hold_request;
   int quiet_cycles;
   int mismatch_total;
   int results_pending;

   dbs_req_if req_if ();
   dbs_rsp_if rsp_if ();

   disc_brush_stamp_framebuffer dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   dbs_frame_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_if),
      .rsp_mon         (rsp_if),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .mismatch_count  (mismatch_total),
      .results_pending (results_pending)
   );

   // 12 ns clock.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Offers one command beat, with random idle cycles ahead of it, and
   // returns at the edge where it is taken.
   task automatic send_beat(input logic [CMD_W-1:0] cmd, input int x, input int y,
                            input logic [COLOR_W-1:0] value);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.command     <= cmd;
      req_if.coord_x     <= x[COORD_W-1:0];
      req_if.coord_y     <= y[COORD_W-1:0];
      req_if.pixel_value <= value;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic write_reg(input csr_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Stops offering and waits until every predicted result has come back.
   task automatic drain_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (results_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Command mix; clears only where the canvas is small enough to be quick.
   function automatic logic [CMD_W-1:0] pick_command(input int area);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) return (area <= SMALL_AREA) ? CMD_CLEAR : CMD_READ;
      if (roll < 30) return CMD_DOT;
      if (roll < 50) return CMD_WRITE_COLOR;
      if (roll < 65) return CMD_WRITE_GREY;
      if (roll < 95) return CMD_READ;
      return CMD_W'(int'(CMD_READ) + int'($urandom_range(1, 3)));
   endfunction

   // Coordinates: mostly a window around a focus point so that reads find
   // painted pixels, some across the whole canvas, a few anywhere at all.
   function automatic int pick_coord(input int extent, input int radius, input int focus);
      int sel, lo, hi;
      sel = $urandom_range(0, 9);
      if (sel == 0) return int'($urandom_range(0, (1 << COORD_W) - 1));
      if (sel <= 2) begin
         lo = -2;
         hi = extent + 1;
      end else begin
         lo = focus - radius - 2;
         hi = focus + ((extent < FOCUS_SPAN) ? extent : FOCUS_SPAN) + radius + 1;
      end
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // One random phase: program all registers while idle, then send items.
   task automatic run_phase(input logic [CSR_DATA_W-1:0] width_word,
                            input logic [CSR_DATA_W-1:0] height_word,
                            input logic [CSR_DATA_W-1:0] radius_word,
                            input logic [CSR_DATA_W-1:0] color_word,
                            input int idle_mode, input int items, input bit squeeze);
      int w, h, r, n, focus_x, focus_y;
      drain_results();
      write_reg(CSR_CANVAS_WIDTH, width_word);
      write_reg(CSR_CANVAS_HEIGHT, height_word);
      write_reg(CSR_BRUSH_RADIUS, radius_word);
      write_reg(CSR_BRUSH_COLOR, color_word);
      w = int'(width_word[WIDTH_REG_W-1:0]);
      h = int'(height_word[WIDTH_REG_W-1:0]);
      r = int'(radius_word[RADIUS_REG_W-1:0]);
      w = (w < DEF_MAX_WIDTH) ? w : DEF_MAX_WIDTH;
      h = (h < DEF_MAX_HEIGHT) ? h : DEF_MAX_HEIGHT;
      r = (r < DEF_MAX_RADIUS) ? r : DEF_MAX_RADIUS;
      focus_x = ($urandom_range(0, 1) && w > FOCUS_SPAN) ? w - FOCUS_SPAN : 0;
      focus_y = ($urandom_range(0, 1) && h > FOCUS_SPAN) ? h - FOCUS_SPAN : 0;
      case (idle_mode)
         1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
         3: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
         default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (n = 0; n < items; n++) begin
         send_beat(pick_command(w * h), pick_coord(w, r, focus_x), pick_coord(h, r, focus_y),
                   $urandom);
         // Long result stall while commands keep coming, so the block backs up.
         if (squeeze && n == 10) hold_request = 1'b1;
      end
   endtask

   // Result-side ready: random stalls, or one long hold-off on request.
   initial begin
      int hold_left;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_if.ready <= 1'b0;
            for (hold_left = LONG_HOLD_CYCLES; hold_left > 0; hold_left--) @(negedge clock);
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog on cycles with no beat on either channel.
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("status: fail");
      $finish;
   end

   // Stimulus and verdict.
   initial begin
      int c;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_CANVAS_WIDTH;
      csr_wr_data        = '0;
      req_if.valid       = 1'b0;
      req_if.command     = CMD_CLEAR;
      req_if.coord_x     = '0;
      req_if.coord_y     = '0;
      req_if.pixel_value = '0;
      send_idle_pct      = 0;
      recv_stall_pct     = 0;
      hold_request       = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed sequence at the reset settings: corners, both channels of
      // out-of-canvas addresses, grey replication, clipped dots, unused
      // codes and a full clear.
      send_beat(CMD_READ, 0, 0, '0);
      send_beat(CMD_WRITE_COLOR, 0, 0, 32'hFFFF_FFFF);
      send_beat(CMD_READ, 0, 0, '0);
      send_beat(CMD_WRITE_COLOR, 255, 255, 32'h0000_0000);
      send_beat(CMD_WRITE_COLOR, 255, 254, 32'h1234_5678);
      send_beat(CMD_READ, 255, 254, '0);
      send_beat(CMD_WRITE_GREY, 1, 0, 32'hA5C3_E75A);
      send_beat(CMD_READ, 1, 0, '0);
      send_beat(CMD_WRITE_COLOR, 256, 0, 32'hDEAD_BEEF);
      send_beat(CMD_WRITE_GREY, 0, 256, 32'h0000_00FF);
      send_beat(CMD_READ, -1, 0, '0);
      send_beat(CMD_READ, 4095, -4096, '0);
      send_beat(CMD_WRITE_COLOR, -4096, 4095, 32'hFFFF_FFFF);
      send_beat(CMD_DOT, 0, 0, '0);
      send_beat(CMD_READ, 0, 0, '0);
      send_beat(CMD_DOT, 255, 255, '0);
      send_beat(CMD_DOT, -3, 128, '0);
      send_beat(CMD_READ, 0, 128, '0);
      for (c = int'(CMD_READ) + 1; c < (1 << CMD_W); c++)
         send_beat(CMD_W'(c), 123, -7, $urandom);
      send_beat(CMD_CLEAR, 0, 0, '0);
      send_beat(CMD_READ, 255, 255, '0);

      // Random phases over a spread of canvas, radius and color settings.
      run_phase(16, 16, 4, {8'hFF, 24'($urandom)}, 0, 200, 1'b0);
      run_phase(1, 1, 0, {8'hFF, 24'($urandom)}, 1, 60, 1'b0);
      run_phase(0, 7, 3, {8'hFF, 24'($urandom)}, 2, 40, 1'b0);
      run_phase(9, 0, 2, 32'h0000_0000, 3, 30, 1'b0);
      run_phase(40, 30, 32, {8'hFF, 24'($urandom)}, 0, 70, 1'b0);
      run_phase(511, 300, 63, {8'($urandom_range(0, 254)), 24'($urandom)}, 1, 40, 1'b0);
      run_phase(256, 256, 5, {8'hFF, 24'($urandom)}, 2, 300, 1'b0);
      run_phase(100, 3, 1, {8'hFF, 24'($urandom)}, 0, 100, 1'b1);
      run_phase(33, 17, 7, 32'hFFFF_FFFF, 3, 250, 1'b0);
      // Junk above each register's width must be dropped.
      run_phase(32'hFFFF_FE05, 32'hABCD_E10C, 32'hFFFF_FFC3, {8'hFF, 24'($urandom)},
                1, 150, 1'b0);
      run_phase(256, 256, 32, {8'hFF, 24'($urandom)}, 0, 20, 1'b0);
      run_phase(24, 24, $urandom_range(0, 12),
                {($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'hFF, 24'($urandom)},
                2, 120, 1'b0);

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_total == 0 && results_pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
